// ----- rtl/core/gic_pkg.sv -----
`default_nettype none

package gic_pkg;

   // buttons that exist on the pad; bits 10 and 11 are unused
   localparam logic [15:0] GIC_DEFINED_BUTTONS = 16'hF3FF;

   localparam logic [7:0]  GIC_TRIGGER_THRESHOLD_RESET    = 8'd30;
   localparam logic [14:0] GIC_LEFT_STICK_DEADZONE_RESET  = 15'd7849;
   localparam logic [14:0] GIC_RIGHT_STICK_DEADZONE_RESET = 15'd8689;

   localparam int GIC_QUEUE_DEPTH  = 2;
   localparam int GIC_NUM_CHANNELS = 6;

   // channel order through the shared divider
   localparam logic [2:0] GIC_CH_LEFT_TRIGGER  = 3'd0;
   localparam logic [2:0] GIC_CH_RIGHT_TRIGGER = 3'd1;
   localparam logic [2:0] GIC_CH_LEFT_X        = 3'd2;
   localparam logic [2:0] GIC_CH_LEFT_Y        = 3'd3;
   localparam logic [2:0] GIC_CH_RIGHT_X       = 3'd4;
   localparam logic [2:0] GIC_CH_RIGHT_Y       = 3'd5;
   localparam logic [2:0] GIC_LAST_CHANNEL     = GIC_CH_RIGHT_Y;

   // two quotient bits per cycle, sixteen bits in all
   localparam logic [2:0] GIC_LAST_STEP = 3'd7;

   typedef struct packed {
      logic [7:0]  trigger_threshold;
      logic [14:0] left_stick_deadzone;
      logic [14:0] right_stick_deadzone;
   } cfg_type;

   typedef struct packed {
      logic [15:0]        buttons;
      logic [7:0]         left_trigger_raw;
      logic [7:0]         right_trigger_raw;
      logic signed [15:0] left_x_raw;
      logic signed [15:0] left_y_raw;
      logic signed [15:0] right_x_raw;
      logic signed [15:0] right_y_raw;
      logic               keyboard_activity;
   } req_type;

   typedef struct packed {
      logic [15:0]        pressed_mask;
      logic [15:0]        released_mask;
      logic [15:0]        left_trigger_value;
      logic [15:0]        right_trigger_value;
      logic signed [15:0] left_x_value;
      logic signed [15:0] left_y_value;
      logic signed [15:0] right_x_value;
      logic signed [15:0] right_y_value;
      logic [3:0]         report_flags;
      logic [1:0]         device_switch;
      logic               active_device;
   } rsp_type;

   // one rescaling job: dividend already carries the full-scale factor
   typedef struct packed {
      logic        zero;
      logic        sat;
      logic        neg;
      logic [29:0] dividend;
      logic [14:0] divisor;
   } chan_type;

   typedef struct packed {
      logic [15:0]                          pressed;
      logic [15:0]                          released;
      logic                                 keyboard;
      chan_type [GIC_NUM_CHANNELS-1:0]      chan;
   } job_type;

   typedef struct packed {
      logic empty;
      logic full;
   } queue_status_type;

   typedef enum logic [1:0] {
      B_IDLE,
      B_LOAD,
      B_DIV,
      B_FINISH
   } back_state_type;

endpackage

`default_nettype wire

// ----- rtl/core/gamepad_input_conditioner.sv -----
// the poll rate is set by the shared divider, which runs the six channels in turn
// (a load step, then the divide steps, for each); the back also picks up the job
// before the channels and hands over the result after them, once the output register is free
// the front takes a new poll while the back works, until the job queue is full
// reset (synchronous, active high) clears button history, activity flags, the
// last device (keyboard and mouse), the queue and the output valid flag; registers go to defaults
`default_nettype none

module gamepad_input_conditioner import gic_pkg::*; #(
   parameter int QUEUE_DEPTH = GIC_QUEUE_DEPTH
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // poll input
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire req_type     req_data,
   // conditioned result
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output rsp_type          rsp_data,
   // register port
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [3:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   // register indexes, word addressed
   localparam logic [1:0] REG_TRIGGER_THRESHOLD    = 2'd0;
   localparam logic [1:0] REG_LEFT_STICK_DEADZONE  = 2'd1;
   localparam logic [1:0] REG_RIGHT_STICK_DEADZONE = 2'd2;

   cfg_type          cfg_ff, cfg_in;
   logic             csr_write;
   logic             push;
   job_type          push_job;
   job_type          head;
   logic             pop;
   queue_status_type q_status;

   // register file: the user must write it only while the block is idle; the block does not enforce this
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_paddr[3:2])
            REG_TRIGGER_THRESHOLD:    cfg_in.trigger_threshold    = csr_pwdata[7:0];
            REG_LEFT_STICK_DEADZONE:  cfg_in.left_stick_deadzone  = csr_pwdata[14:0];
            REG_RIGHT_STICK_DEADZONE: cfg_in.right_stick_deadzone = csr_pwdata[14:0];
            default: begin
               // unmapped word, write ignored
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.trigger_threshold    <= GIC_TRIGGER_THRESHOLD_RESET;
         cfg_ff.left_stick_deadzone  <= GIC_LEFT_STICK_DEADZONE_RESET;
         cfg_ff.right_stick_deadzone <= GIC_RIGHT_STICK_DEADZONE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      unique case (csr_paddr[3:2])
         REG_TRIGGER_THRESHOLD:    csr_prdata = 32'(cfg_ff.trigger_threshold);
         REG_LEFT_STICK_DEADZONE:  csr_prdata = 32'(cfg_ff.left_stick_deadzone);
         REG_RIGHT_STICK_DEADZONE: csr_prdata = 32'(cfg_ff.right_stick_deadzone);
         default:                  csr_prdata = '0;
      endcase
   end

   // front: button edges, dead zone tests and dividend set-up on each transfer
   gic_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .cfg        (cfg_ff),
      .queue_full (q_status.full),
      .push       (push),
      .job        (push_job)
   );

   // short job queue decoupling the front from the divider
   gic_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head     (head),
      .status   (q_status)
   );

   // back: shared divider over six channels, report flags, device tracking,
   // output register so a finished result can wait while the next job runs
   gic_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .q_status  (q_status),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

// ----- rtl/core/gic_front.sv -----
`default_nettype none

module gic_front import gic_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   input  wire cfg_type cfg,
   input  wire logic    queue_full,
   output logic         push,
   output job_type      job
);

   logic [15:0] prev_buttons_ff;
   logic [15:0] prev_buttons_in;
   logic [15:0] delta;

   function automatic chan_type trigger_chan(input logic [7:0] raw, input logic [7:0] thr);
      logic [7:0]  n;
      logic [23:0] prod;
      chan_type    c;
      n          = raw - thr;
      prod       = {n, 16'h0000} - 24'(n);
      c.zero     = (raw <= thr);
      c.sat      = 1'b0;
      c.neg      = 1'b0;
      c.dividend = 30'(prod);
      c.divisor  = 15'(8'hFF - thr);
      return c;
   endfunction

   function automatic chan_type axis_chan(input logic [15:0] raw, input logic [14:0] dz);
      logic [15:0] mag;
      logic [15:0] n;
      logic [30:0] prod;
      chan_type    c;
      mag        = raw[15] ? 16'(~raw + 16'd1) : raw;
      n          = mag - {1'b0, dz};
      prod       = {n, 15'h0000} - 31'(n);
      c.zero     = (mag <= {1'b0, dz});
      // full-scale magnitude or widest dead zone: result pins at full scale
      c.sat      = !c.zero && ((mag == 16'h8000) || (dz == 15'h7FFF));
      c.neg      = raw[15];
      c.dividend = prod[29:0];
      c.divisor  = 15'h7FFF - dz;
      return c;
   endfunction

   assign req_stall = queue_full;
   assign push      = req_valid && !queue_full;

   assign delta = req_data.buttons ^ prev_buttons_ff;

   always_comb begin
      job.pressed  = delta & req_data.buttons & GIC_DEFINED_BUTTONS;
      job.released = delta & prev_buttons_ff & GIC_DEFINED_BUTTONS;
      job.keyboard = req_data.keyboard_activity;
      job.chan[GIC_CH_LEFT_TRIGGER]  = trigger_chan(req_data.left_trigger_raw,
                                                    cfg.trigger_threshold);
      job.chan[GIC_CH_RIGHT_TRIGGER] = trigger_chan(req_data.right_trigger_raw,
                                                    cfg.trigger_threshold);
      job.chan[GIC_CH_LEFT_X]  = axis_chan(req_data.left_x_raw, cfg.left_stick_deadzone);
      job.chan[GIC_CH_LEFT_Y]  = axis_chan(req_data.left_y_raw, cfg.left_stick_deadzone);
      job.chan[GIC_CH_RIGHT_X] = axis_chan(req_data.right_x_raw, cfg.right_stick_deadzone);
      job.chan[GIC_CH_RIGHT_Y] = axis_chan(req_data.right_y_raw, cfg.right_stick_deadzone);
   end

   assign prev_buttons_in = push ? req_data.buttons : prev_buttons_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_buttons_ff <= '0;
      end else begin
         prev_buttons_ff <= prev_buttons_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/core/gic_queue.sv -----
`default_nettype none

module gic_queue import gic_pkg::*; #(
   parameter int DEPTH = GIC_QUEUE_DEPTH
) (
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      push,
   input  wire job_type   push_job,
   input  wire logic      pop,
   output job_type        head,
   output queue_status_type status
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   job_type           mem_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   assign status.empty = (count_ff == '0);
   assign status.full  = (count_ff == FULL_CNT);
   assign head         = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/core/gic_back.sv -----
`default_nettype none

module gic_back import gic_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire job_type          head,
   input  wire queue_status_type q_status,
   output logic                  pop,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output rsp_type               rsp_data
);

   back_state_type state_ff, state_in;
   logic [2:0]     ch_ff, ch_in;
   logic [2:0]     step_ff, step_in;
   logic [14:0]    rem_ff, rem_in;
   logic [15:0]    lo_ff, lo_in;
   logic [15:0]    q_ff, q_in;
   logic [GIC_NUM_CHANNELS-1:0][15:0] res_ff;
   logic [3:0]     was_ff, was_in;
   logic           last_dev_ff, last_dev_in;
   logic           out_valid_ff, out_valid_in;
   rsp_type        out_ff, out_in;

   chan_type       cur;
   logic [15:0]    r1, r1s, r2, r2s, d16;
   logic           ge1, ge2;
   logic [15:0]    q_next;
   logic [15:0]    mag;
   logic [15:0]    chan_value;
   logic           res_wr;
   logic           out_load;
   logic [3:0]     nz;
   logic [3:0]     flags;
   logic           kb_sw, gp_sw, dev_mid;

   assign cur = head.chan[ch_ff];

   // restoring division, two quotient bits per cycle
   assign d16    = {1'b0, cur.divisor};
   assign r1     = {rem_ff, lo_ff[15]};
   assign ge1    = (r1 >= d16);
   assign r1s    = ge1 ? r1 - d16 : r1;
   assign r2     = {r1s[14:0], lo_ff[14]};
   assign ge2    = (r2 >= d16);
   assign r2s    = ge2 ? r2 - d16 : r2;
   assign q_next = {q_ff[13:0], ge1, ge2};

   assign mag        = cur.zero ? 16'h0000 : (cur.sat ? 16'h7FFF : q_next);
   assign chan_value = cur.neg ? 16'(~mag + 16'd1) : mag;

   always_comb begin
      state_in = state_ff;
      ch_in    = ch_ff;
      step_in  = step_ff;
      rem_in   = rem_ff;
      lo_in    = lo_ff;
      q_in     = q_ff;
      res_wr   = 1'b0;
      pop      = 1'b0;
      out_load = 1'b0;
      unique case (state_ff)
         B_IDLE: begin
            if (!q_status.empty) begin
               state_in = B_LOAD;
            end
         end
         B_LOAD: begin
            rem_in   = 15'(cur.dividend[29:16]);
            lo_in    = cur.dividend[15:0];
            q_in     = '0;
            step_in  = '0;
            state_in = B_DIV;
         end
         B_DIV: begin
            rem_in  = r2s[14:0];
            lo_in   = {lo_ff[13:0], 2'b00};
            q_in    = q_next;
            step_in = step_ff + 3'd1;
            if (step_ff == GIC_LAST_STEP) begin
               res_wr = 1'b1;
               if (ch_ff == GIC_LAST_CHANNEL) begin
                  ch_in    = '0;
                  state_in = B_FINISH;
               end else begin
                  ch_in    = ch_ff + 3'd1;
                  state_in = B_LOAD;
               end
            end
         end
         B_FINISH: begin
            if (!out_valid_ff || !rsp_stall) begin
               out_load = 1'b1;
               pop      = 1'b1;
               state_in = B_IDLE;
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   // report flags and device tracking
   always_comb begin
      nz[0]   = (res_ff[GIC_CH_LEFT_TRIGGER] != '0);
      nz[1]   = (res_ff[GIC_CH_RIGHT_TRIGGER] != '0);
      nz[2]   = ((res_ff[GIC_CH_LEFT_X] | res_ff[GIC_CH_LEFT_Y]) != '0);
      nz[3]   = ((res_ff[GIC_CH_RIGHT_X] | res_ff[GIC_CH_RIGHT_Y]) != '0);
      flags   = nz | was_ff;
      kb_sw   = head.keyboard && last_dev_ff;
      dev_mid = kb_sw ? 1'b0 : last_dev_ff;
      gp_sw   = ((head.pressed != '0) || (head.released != '0) || (flags != '0))
                && !dev_mid;

      out_in.pressed_mask        = head.pressed;
      out_in.released_mask       = head.released;
      out_in.left_trigger_value  = res_ff[GIC_CH_LEFT_TRIGGER];
      out_in.right_trigger_value = res_ff[GIC_CH_RIGHT_TRIGGER];
      out_in.left_x_value        = res_ff[GIC_CH_LEFT_X];
      out_in.left_y_value        = res_ff[GIC_CH_LEFT_Y];
      out_in.right_x_value       = res_ff[GIC_CH_RIGHT_X];
      out_in.right_y_value       = res_ff[GIC_CH_RIGHT_Y];
      out_in.report_flags        = flags;
      out_in.device_switch       = {gp_sw, kb_sw};
      out_in.active_device       = gp_sw ? 1'b1 : dev_mid;

      was_in       = out_load ? nz : was_ff;
      last_dev_in  = out_load ? out_in.active_device : last_dev_ff;
      out_valid_in = out_load ? 1'b1 : (rsp_stall ? out_valid_ff : 1'b0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         ch_ff        <= '0;
         step_ff      <= '0;
         was_ff       <= '0;
         last_dev_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ch_ff        <= ch_in;
         step_ff      <= step_in;
         was_ff       <= was_in;
         last_dev_ff  <= last_dev_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      lo_ff  <= lo_in;
      q_ff   <= q_in;
      if (res_wr) begin
         res_ff[ch_ff] <= chan_value;
      end
      if (out_load) begin
         out_ff <= out_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   a_busy_needs_job: assert property (@(posedge clock) disable iff (reset)
      (state_ff != B_IDLE) |-> !q_status.empty)
      else $error("back busy with no job at queue head");

   a_channel_range: assert property (@(posedge clock) disable iff (reset)
      ch_ff <= GIC_LAST_CHANNEL)
      else $error("channel counter out of range");

   a_gamepad_switch: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_ff.device_switch[1]) |-> out_ff.active_device)
      else $error("gamepad switch without gamepad active");

   a_keyboard_switch: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && (out_ff.device_switch == 2'b01)) |-> !out_ff.active_device)
      else $error("keyboard switch without keyboard active");

   a_result_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid_ff) |-> ($past(state_ff) == B_FINISH))
      else $error("result raised outside finish state");

endmodule

`default_nettype wire
